[design/assert_macros.svh]
// Assertion helpers used by the top-level RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Condition that must hold at every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error(msg);

`endif

[design/mabf_pkg.sv]
`default_nettype none
package mabf_pkg;

   localparam int NUM_ANGLES = 90;
   localparam int ANGLE_W    = 7;
   localparam int COORD_W    = 16;
   localparam int ROT_W      = 18;
   localparam int EXT_W      = 18;
   localparam int AREA_W     = 34;

   localparam logic [14:0] CUT_RESET  = 15'd77;
   localparam logic [10:0] MINP_RESET = 11'd3;

   localparam logic CSR_CUT  = 1'b0;
   localparam logic CSR_MINP = 1'b1;

   // Per-angle extents, one record per cell.
   typedef struct packed {
      logic signed [ROT_W-1:0] min_x;
      logic signed [ROT_W-1:0] max_x;
      logic signed [ROT_W-1:0] min_y;
      logic signed [ROT_W-1:0] max_y;
   } ext_type;

   // Point as it travels down the cell row.
   typedef struct packed {
      logic                      valid;
      logic                      first;
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
   } pnt_type;

   // Control from the sequencer to the row.
   typedef struct packed {
      logic shift_out;
   } row_ctl_type;

   function automatic logic [13:0] sin_q14(input logic [6:0] deg);
      logic [13:0] v;
      case (deg)
         7'd0: v = 14'd0;         7'd1: v = 14'd286;      7'd2: v = 14'd572;
         7'd3: v = 14'd857;       7'd4: v = 14'd1143;     7'd5: v = 14'd1428;
         7'd6: v = 14'd1713;      7'd7: v = 14'd1997;     7'd8: v = 14'd2280;
         7'd9: v = 14'd2563;      7'd10: v = 14'd2845;    7'd11: v = 14'd3126;
         7'd12: v = 14'd3406;     7'd13: v = 14'd3686;    7'd14: v = 14'd3964;
         7'd15: v = 14'd4240;     7'd16: v = 14'd4516;    7'd17: v = 14'd4790;
         7'd18: v = 14'd5063;     7'd19: v = 14'd5334;    7'd20: v = 14'd5604;
         7'd21: v = 14'd5872;     7'd22: v = 14'd6138;    7'd23: v = 14'd6402;
         7'd24: v = 14'd6664;     7'd25: v = 14'd6924;    7'd26: v = 14'd7182;
         7'd27: v = 14'd7438;     7'd28: v = 14'd7692;    7'd29: v = 14'd7943;
         7'd30: v = 14'd8192;     7'd31: v = 14'd8438;    7'd32: v = 14'd8682;
         7'd33: v = 14'd8923;     7'd34: v = 14'd9162;    7'd35: v = 14'd9397;
         7'd36: v = 14'd9630;     7'd37: v = 14'd9860;    7'd38: v = 14'd10087;
         7'd39: v = 14'd10311;    7'd40: v = 14'd10531;   7'd41: v = 14'd10749;
         7'd42: v = 14'd10963;    7'd43: v = 14'd11174;   7'd44: v = 14'd11381;
         7'd45: v = 14'd11585;    7'd46: v = 14'd11786;   7'd47: v = 14'd11983;
         7'd48: v = 14'd12176;    7'd49: v = 14'd12365;   7'd50: v = 14'd12551;
         7'd51: v = 14'd12733;    7'd52: v = 14'd12911;   7'd53: v = 14'd13085;
         7'd54: v = 14'd13255;    7'd55: v = 14'd13421;   7'd56: v = 14'd13583;
         7'd57: v = 14'd13741;    7'd58: v = 14'd13894;   7'd59: v = 14'd14044;
         7'd60: v = 14'd14189;    7'd61: v = 14'd14330;   7'd62: v = 14'd14466;
         7'd63: v = 14'd14598;    7'd64: v = 14'd14726;   7'd65: v = 14'd14849;
         7'd66: v = 14'd14968;    7'd67: v = 14'd15082;   7'd68: v = 14'd15191;
         7'd69: v = 14'd15296;    7'd70: v = 14'd15396;   7'd71: v = 14'd15491;
         7'd72: v = 14'd15582;    7'd73: v = 14'd15668;   7'd74: v = 14'd15749;
         7'd75: v = 14'd15826;    7'd76: v = 14'd15897;   7'd77: v = 14'd15964;
         7'd78: v = 14'd16026;    7'd79: v = 14'd16083;   7'd80: v = 14'd16135;
         7'd81: v = 14'd16182;    7'd82: v = 14'd16225;   7'd83: v = 14'd16262;
         7'd84: v = 14'd16294;    7'd85: v = 14'd16322;   7'd86: v = 14'd16344;
         7'd87: v = 14'd16362;    7'd88: v = 14'd16374;   7'd89: v = 14'd16382;
         default: v = 14'd0;
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

[design/mabf_cell.sv]
`default_nettype none
module mabf_cell
   import mabf_pkg::*;
#(
   parameter int TRIG_FRAC_BITS = 14,
   parameter int ANGLE = 0
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire pnt_type pnt_in,
   output pnt_type      pnt_out,
   input  wire row_ctl_type ctl,
   input  wire ext_type ext_prev,
   output ext_type      ext_out
);

   localparam int TW  = TRIG_FRAC_BITS + 2;
   localparam int PW  = COORD_W + TW + 1;
   localparam int UP  = (TRIG_FRAC_BITS > 14) ? TRIG_FRAC_BITS - 14 : 0;
   localparam int DN  = (TRIG_FRAC_BITS < 14) ? 14 - TRIG_FRAC_BITS : 0;

   function automatic logic signed [TW-1:0] trig(input logic [6:0] deg);
      logic [TW+15:0] v;
      v = {{(TW+2){1'b0}}, sin_q14(deg)};
      if (deg == 7'd90) v = (TW+16)'(16384);
      v = v << UP;
      if (DN != 0) v = (v + ((TW+16)'(1) << (DN - 1))) >> DN;
      return TW'(v);
   endfunction

   localparam logic signed [TW-1:0] COS_V = trig(7'(90 - ANGLE));
   localparam logic signed [TW-1:0] SIN_V = trig(7'(ANGLE));

   pnt_type pnt_ff;
   logic signed [PW-1:0] xc_ff, ys_ff, yc_ff, xs_ff;
   logic stage_v_ff, stage_f_ff;
   ext_type ext_ff;

   logic signed [PW:0] rx_full, ry_full;
   logic signed [ROT_W-1:0] rx, ry;

   always_ff @(posedge clock) begin
      if (reset) begin
         pnt_ff.valid <= 1'b0;
         stage_v_ff   <= 1'b0;
      end else begin
         pnt_ff.valid <= pnt_in.valid;
         stage_v_ff   <= pnt_in.valid;
      end
      pnt_ff.first <= pnt_in.first;
      pnt_ff.x     <= pnt_in.x;
      pnt_ff.y     <= pnt_in.y;
      stage_f_ff   <= pnt_in.first;
      xc_ff <= PW'(pnt_in.x) * PW'(COS_V);
      ys_ff <= PW'(pnt_in.y) * PW'(SIN_V);
      yc_ff <= PW'(pnt_in.y) * PW'(COS_V);
      xs_ff <= PW'(pnt_in.x) * PW'(SIN_V);
   end

   // arithmetic shift floors
   assign rx_full = (PW+1)'(xc_ff) + (PW+1)'(ys_ff);
   assign ry_full = (PW+1)'(yc_ff) - (PW+1)'(xs_ff);
   assign rx = ROT_W'(rx_full >>> TRIG_FRAC_BITS);
   assign ry = ROT_W'(ry_full >>> TRIG_FRAC_BITS);

   always_ff @(posedge clock) begin
      if (ctl.shift_out) begin
         ext_ff <= ext_prev;
      end else if (stage_v_ff) begin
         if (stage_f_ff || rx < ext_ff.min_x) ext_ff.min_x <= rx;
         if (stage_f_ff || rx > ext_ff.max_x) ext_ff.max_x <= rx;
         if (stage_f_ff || ry < ext_ff.min_y) ext_ff.min_y <= ry;
         if (stage_f_ff || ry > ext_ff.max_y) ext_ff.max_y <= ry;
      end
   end

   assign pnt_out = pnt_ff;
   assign ext_out = ext_ff;

endmodule
`default_nettype wire

[design/mabf_row.sv]
`default_nettype none
module mabf_row
   import mabf_pkg::*;
#(
   parameter int TRIG_FRAC_BITS = 14
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire pnt_type     pnt_in,
   input  wire row_ctl_type ctl,
   output ext_type          ext_head
);

   pnt_type pnt_chain [NUM_ANGLES+1];
   ext_type ext_chain [NUM_ANGLES+1];

   assign pnt_chain[0] = pnt_in;
   assign ext_chain[NUM_ANGLES] = '0;

   // Cell k holds angle k; extents shift toward cell 0 for readout.
   for (genvar k = 0; k < NUM_ANGLES; k++) begin : g_cell
      mabf_cell #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS), .ANGLE(k)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .pnt_in   (pnt_chain[k]),
         .pnt_out  (pnt_chain[k+1]),
         .ctl      (ctl),
         .ext_prev (ext_chain[k+1]),
         .ext_out  (ext_chain[k])
      );
   end

   assign ext_head = ext_chain[0];

endmodule
`default_nettype wire

[design/min_area_box_fit_top.sv]
// Minimum-area box fit for one point cluster.
// req_ channel: one point per transaction, tdata = {z, y, x} (x lowest), tlast marks
// the final point. rsp_ channel: one box per cluster. csr_: write port, index 0 is
// cut_height_offset, index 1 min_points_above; write only while idle.
// Points are taken one per cycle while the block is loading, and stored (up to
// MAX_POINTS; extra are dropped and flagged). After the last point, the block counts
// points above the cut, then streams the kept points (all points if fewer than
// min_points_above lie above the cut) once through a row of 90 angle cells and lets
// the row drain, shifts the 90 extents out while tracking the best area (one multiply
// per cycle), and computes the center from four products in turn. One cluster is in
// work at a time. The store read port sets both passes.
// Reset clears the point count, z range and best-area search; the registers reset too.
// A box waiting on rsp_tready is held in the output register; points of the next
// cluster are still taken, and that cluster waits before its output step.
`default_nettype none
module min_area_box_fit_top
   import mabf_pkg::*;
#(
   parameter int MAX_POINTS = 1024,
   parameter int TRIG_FRAC_BITS = 14
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [47:0]  req_tdata,   // point_x, point_y, point_z
   input  wire logic         req_tlast,   // last_point
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [111:0]      rsp_tdata,   // center_x, center_y, center_z, box_length,
                                          // box_width, box_height, yaw_degrees, pad
   output logic [1:0]        rsp_tuser,   // used_all_points, points_dropped
   input  wire logic         csr_we,
   input  wire logic [0:0]   csr_index,
   input  wire logic [14:0]  csr_wdata
);
`include "assert_macros.svh"

   localparam int AW = $clog2(MAX_POINTS);
   localparam int CW = AW + 1;
   localparam int TW = TRIG_FRAC_BITS + 2;
   localparam int FL = 95; // drain: row length plus cell pipeline

   typedef enum logic [6:0] {
      ST_LOAD  = 7'b0000001,
      ST_COUNT = 7'b0000010,
      ST_SWEEP = 7'b0000100,
      ST_DRAIN = 7'b0001000,
      ST_SCAN  = 7'b0010000,
      ST_CENT  = 7'b0100000,
      ST_OUT   = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   logic [14:0] cut_ff;
   logic [10:0] minp_ff;
   logic [47:0] mem [MAX_POINTS];
   logic [47:0] rd_ff;
   logic [CW-1:0] cnt_ff, idx_ff, kept_ff;
   logic signed [COORD_W-1:0] lo_ff, hi_ff;
   logic ovf_ff, use_all_ff, rd_v_ff, first_ff;
   logic [6:0] step_ff;
   logic [AREA_W-1:0] best_area_ff;
   logic [ANGLE_W-1:0] best_k_ff;
   ext_type best_ext_ff;
   logic [2:0] cphase_ff;
   logic out_v_ff;

   logic req_acc, store_ok, out_rdy;
   logic signed [16:0] thr;
   logic above;
   pnt_type pnt_in;
   row_ctl_type ctl;
   ext_type head;

   assign req_tready = (state_ff == ST_LOAD);
   assign req_acc = req_tvalid && req_tready;
   assign store_ok = cnt_ff < CW'(MAX_POINTS);
   assign out_rdy = !out_v_ff || rsp_tready;
   assign thr = 17'(lo_ff) + 17'($signed({1'b0, cut_ff}));
   assign above = 17'($signed(rd_ff[47:32])) > thr;

   always_ff @(posedge clock) begin
      if (reset) begin
         cut_ff  <= CUT_RESET;
         minp_ff <= MINP_RESET;
      end else if (csr_we) begin
         if (csr_index == CSR_CUT) cut_ff <= csr_wdata;
         else minp_ff <= csr_wdata[10:0];
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc && store_ok) mem[cnt_ff[AW-1:0]] <= req_tdata;
      rd_ff <= mem[idx_ff[AW-1:0]];
   end

   // point feed into the row
   always_comb begin
      pnt_in.valid = (state_ff == ST_SWEEP) && rd_v_ff && (use_all_ff || above);
      pnt_in.first = first_ff;
      pnt_in.x = $signed(rd_ff[15:0]);
      pnt_in.y = $signed(rd_ff[31:16]);
      ctl.shift_out = (state_ff == ST_SCAN);
   end

   mabf_row #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_row (
      .clock(clock), .reset(reset), .pnt_in(pnt_in), .ctl(ctl), .ext_head(head)
   );

   // scan: area of the extents at the row head
   logic [EXT_W-1:0] dx_h, dy_h, dx_b, dy_b;
   logic [AREA_W+1:0] area_h;
   assign dx_h = EXT_W'(head.max_x - head.min_x);
   assign dy_h = EXT_W'(head.max_y - head.min_y);
   assign area_h = (AREA_W+2)'(dx_h) * (AREA_W+2)'(dy_h);
   assign dx_b = EXT_W'(best_ext_ff.max_x - best_ext_ff.min_x);
   assign dy_b = EXT_W'(best_ext_ff.max_y - best_ext_ff.min_y);

   // center: four products over cycles
   logic signed [TW-1:0] cos_b, sin_b;
   logic signed [18:0] sx, sy;
   logic signed [19+TW:0] p_ff, acc_ff, cx_ff;
   logic signed [19+TW:0] cy_sh, cx_sh;
   function automatic logic signed [TW-1:0] trig(input logic [6:0] deg);
      logic [TW+15:0] v;
      v = {{(TW+2){1'b0}}, sin_q14(deg)};
      if (deg == 7'd90) v = (TW+16)'(16384);
      if (TRIG_FRAC_BITS > 14) v = v << (TRIG_FRAC_BITS - 14);
      if (TRIG_FRAC_BITS < 14)
         v = (v + ((TW+16)'(1) << (13 - TRIG_FRAC_BITS))) >> (14 - TRIG_FRAC_BITS);
      return TW'(v);
   endfunction
   assign cos_b = trig(7'(7'd90 - best_k_ff));
   assign sin_b = trig(best_k_ff);
   assign sx = 19'(best_ext_ff.min_x) + 19'(best_ext_ff.max_x);
   assign sy = 19'(best_ext_ff.min_y) + 19'(best_ext_ff.max_y);

   logic signed [19+TW:0] mul_a;
   always_comb begin
      case (cphase_ff)
         3'd0: mul_a = (20+TW)'(sx) * (20+TW)'(cos_b);
         3'd1: mul_a = -((20+TW)'(sy) * (20+TW)'(sin_b));
         3'd2: mul_a = (20+TW)'(sx) * (20+TW)'(sin_b);
         3'd3: mul_a = (20+TW)'(sy) * (20+TW)'(cos_b);
         default: mul_a = '0;
      endcase
   end
   assign cx_sh = cx_ff >>> (TRIG_FRAC_BITS + 1);
   assign cy_sh = (acc_ff + p_ff) >>> (TRIG_FRAC_BITS + 1);

   function automatic logic [15:0] sat16(input logic signed [19+TW:0] v);
      if (v > (20+TW)'(32767)) return 16'h7FFF;
      if (v < -(20+TW)'(32768)) return 16'h8000;
      return v[15:0];
   endfunction

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD:  if (req_acc && req_tlast) state_in = ST_COUNT;
         ST_COUNT: if (!rd_v_ff && idx_ff == cnt_ff && idx_ff != '0 ||
                       cnt_ff == '0) state_in = ST_SWEEP;
         ST_SWEEP: if (idx_ff == cnt_ff && !rd_v_ff) state_in = ST_DRAIN;
         ST_DRAIN: if (step_ff == 7'(FL)) state_in = ST_SCAN;
         ST_SCAN:  if (step_ff == 7'(NUM_ANGLES - 1)) state_in = ST_CENT;
         ST_CENT:  if (cphase_ff == 3'd3) state_in = ST_OUT;
         ST_OUT:   if (out_rdy) state_in = ST_LOAD;
         default:  state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         cnt_ff <= '0;
         lo_ff <= 16'sh7FFF;
         hi_ff <= -16'sh8000;
         ovf_ff <= 1'b0;
         rd_v_ff <= 1'b0;
         idx_ff <= '0;
         step_ff <= '0;
         cphase_ff <= '0;
         best_area_ff <= '1;
         best_k_ff <= '0;
      end else begin
         state_ff <= state_in;
         case (state_ff)
            ST_LOAD: begin
               if (req_acc) begin
                  if (store_ok) begin
                     cnt_ff <= cnt_ff + 1'b1;
                     if ($signed(req_tdata[47:32]) < lo_ff) lo_ff <= req_tdata[47:32];
                     if ($signed(req_tdata[47:32]) > hi_ff) hi_ff <= req_tdata[47:32];
                  end else begin
                     ovf_ff <= 1'b1;
                  end
               end
               idx_ff <= '0;
               rd_v_ff <= 1'b0;
               kept_ff <= '0;
            end
            ST_COUNT: begin
               if (rd_v_ff && above) kept_ff <= kept_ff + 1'b1;
               if (state_in == ST_SWEEP) begin
                  idx_ff <= '0;
                  rd_v_ff <= 1'b0;
                  first_ff <= 1'b1;
               end else begin
                  rd_v_ff <= idx_ff != cnt_ff;
                  if (idx_ff != cnt_ff) idx_ff <= idx_ff + 1'b1;
               end
            end
            ST_SWEEP: begin
               rd_v_ff <= idx_ff != cnt_ff;
               if (idx_ff != cnt_ff) idx_ff <= idx_ff + 1'b1;
               if (pnt_in.valid) first_ff <= 1'b0;
               step_ff <= '0;
            end
            ST_DRAIN: step_ff <= (state_in == ST_SCAN) ? '0 : step_ff + 1'b1;
            ST_SCAN: begin
               step_ff <= step_ff + 1'b1;
               if (area_h < (AREA_W+2)'(best_area_ff)) begin
                  best_area_ff <= AREA_W'(area_h);
                  best_k_ff <= step_ff;
                  best_ext_ff <= head;
               end
               cphase_ff <= '0;
            end
            ST_CENT: begin
               cphase_ff <= cphase_ff + 1'b1;
               p_ff <= mul_a;
               case (cphase_ff)
                  3'd1: acc_ff <= p_ff;
                  3'd2: cx_ff <= acc_ff + p_ff;
                  3'd3: acc_ff <= p_ff;
                  default: ;
               endcase
            end
            ST_OUT: if (out_rdy) begin
               cnt_ff <= '0;
               lo_ff <= 16'sh7FFF;
               hi_ff <= -16'sh8000;
               ovf_ff <= 1'b0;
               best_area_ff <= '1;
               best_k_ff <= '0;
            end
            default: ;
         endcase
      end
   end

   // use_all settles once the count pass is done
   always_ff @(posedge clock) begin
      if (state_ff == ST_SWEEP && idx_ff == '0 && !rd_v_ff)
         use_all_ff <= (kept_ff < CW'(minp_ff)) || (kept_ff == '0);
   end

   // result register
   logic [15:0] cx_o, cy_o, cz_o, h_o;
   logic [16:0] len_o, wid_o;
   logic [7:0] yaw_o;
   logic all_o, ovf_o;
   logic [16:0] zsum;
   assign zsum = 17'(lo_ff) + 17'(hi_ff);
   always_ff @(posedge clock) begin
      if (state_ff == ST_OUT && out_rdy) begin
         cx_o <= sat16(cx_sh);
         cy_o <= sat16(cy_sh);
         cz_o <= zsum[16:1];
         h_o <= 16'(hi_ff - lo_ff);
         all_o <= use_all_ff;
         ovf_o <= ovf_ff;
         if (dx_b < dy_b) begin
            len_o <= 17'(dy_b); wid_o <= 17'(dx_b); yaw_o <= 8'(best_k_ff) + 8'd90;
         end else begin
            len_o <= 17'(dx_b); wid_o <= 17'(dy_b); yaw_o <= 8'(best_k_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (state_ff == ST_OUT && out_rdy) begin
         out_v_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_v_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata = {6'd0, yaw_o, h_o, wid_o, len_o, cz_o, cy_o, cx_o};
   assign rsp_tuser = {ovf_o, all_o};

   `ASSERT_IMPL(a_no_req_busy, clock, reset, state_ff != ST_LOAD, !req_tready,
                "point taken while busy")
   `ASSERT_ALWAYS(a_cnt_bound, clock, reset, cnt_ff <= CW'(MAX_POINTS),
                  "point count beyond store")
   `ASSERT_IMPL(a_out_hold, clock, reset, rsp_tvalid && !rsp_tready, ##1 rsp_tvalid,
                "result dropped before taken")

endmodule
`default_nettype wire

[bench/tb_top.sv]
`default_nettype none
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import mabf_pkg::*;

   localparam int STORE_DEPTH = 1024;
   localparam int FRAC = 14;

   typedef struct {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] z;
      logic               last;
   } point_type;

   typedef struct packed {
      logic signed [15:0] cx;
      logic signed [15:0] cy;
      logic signed [15:0] cz;
      logic [16:0]        len;
      logic [16:0]        wid;
      logic [15:0]        hgt;
      logic [7:0]         yaw;
      logic               all_used;
      logic               dropped;
   } box_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [47:0] req_tdata = '0;
   logic req_tlast = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [111:0] rsp_tdata;
   logic [1:0] rsp_tuser;
   logic csr_we = 1'b0;
   logic [0:0] csr_index = CSR_CUT;
   logic [14:0] csr_wdata = '0;

   min_area_box_fit_top dut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // predictor state
   logic signed [15:0] cl_x [STORE_DEPTH];
   logic signed [15:0] cl_y [STORE_DEPTH];
   logic signed [15:0] cl_z [STORE_DEPTH];
   int cl_count = 0;
   int lo_z = 32767, hi_z = -32768;
   bit cl_over = 0;
   int cut_ofs = 77, min_above = 3;

   point_type pending_pts[$];
   box_type   boxes_due[$];
   int send_idle_pct = 0, recv_stall_pct = 0;
   int errors = 0, boxes_seen = 0, points_sent = 0;
   longint cycles = 0;

   function automatic longint trig(int deg);
      return longint'(deg >= 90 ? 16384 : sin_q14(deg[6:0]));
   endfunction

   function automatic longint fl_shr(longint v, int sh);
      return v >>> sh;
   endfunction

   function automatic int sat_s16(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return int'(v);
   endfunction

   task automatic fit_point(point_type p);
      int thr, kept, k, i, best_k, mnx, mxx, mny, mxy, rx, ry;
      int ex_mnx[90], ex_mxx[90], ex_mny[90], ex_mxy[90];
      longint c, s, area, best, sx, sy, dx, dy;
      bit all_pts, first;
      box_type b;
      if (cl_count < STORE_DEPTH) begin
         cl_x[cl_count] = p.x; cl_y[cl_count] = p.y; cl_z[cl_count] = p.z;
         cl_count++;
         if (p.z < lo_z) lo_z = p.z;
         if (p.z > hi_z) hi_z = p.z;
      end else cl_over = 1;
      if (!p.last) return;
      thr = lo_z + cut_ofs;
      kept = 0;
      for (i = 0; i < cl_count; i++) if (cl_z[i] > thr) kept++;
      all_pts = (kept < min_above) || (kept == 0);
      best = (64'd1 << 34) - 1;
      best_k = 0;
      for (k = 0; k < 90; k++) begin
         c = trig(90 - k); s = trig(k);
         first = 1; mnx = 0; mxx = 0; mny = 0; mxy = 0;
         for (i = 0; i < cl_count; i++) begin
            if (!all_pts && cl_z[i] <= thr) continue;
            rx = int'(fl_shr(longint'(cl_x[i]) * c + longint'(cl_y[i]) * s, FRAC));
            ry = int'(fl_shr(longint'(cl_y[i]) * c - longint'(cl_x[i]) * s, FRAC));
            if (first || rx < mnx) mnx = rx;
            if (first || rx > mxx) mxx = rx;
            if (first || ry < mny) mny = ry;
            if (first || ry > mxy) mxy = ry;
            first = 0;
         end
         ex_mnx[k] = mnx; ex_mxx[k] = mxx; ex_mny[k] = mny; ex_mxy[k] = mxy;
         area = longint'(mxx - mnx) * longint'(mxy - mny);
         if (area < best) begin
            best = area; best_k = k;
         end
      end
      c = trig(90 - best_k); s = trig(best_k);
      sx = longint'(ex_mnx[best_k]) + ex_mxx[best_k];
      sy = longint'(ex_mny[best_k]) + ex_mxy[best_k];
      b.cx = 16'(sat_s16(fl_shr(sx * c - sy * s, FRAC + 1)));
      b.cy = 16'(sat_s16(fl_shr(sx * s + sy * c, FRAC + 1)));
      b.cz = 16'(fl_shr(longint'(lo_z) + hi_z, 1));
      dx = ex_mxx[best_k] - ex_mnx[best_k];
      dy = ex_mxy[best_k] - ex_mny[best_k];
      b.yaw = 8'(best_k);
      if (dx < dy) begin
         b.len = 17'(dy); b.wid = 17'(dx); b.yaw = 8'(best_k + 90);
      end else begin
         b.len = 17'(dx); b.wid = 17'(dy);
      end
      b.hgt = 16'(hi_z - lo_z);
      b.all_used = all_pts;
      b.dropped = cl_over;
      boxes_due.insert(boxes_due.size(), b);
      cl_count = 0; lo_z = 32767; hi_z = -32768; cl_over = 0;
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (pending_pts.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            point_type p;
            p = pending_pts.pop_front();
            req_tvalid <= 1'b1;
            req_tdata <= {p.z, p.y, p.x};
            req_tlast <= p.last;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // predict on acceptance
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         point_type p;
         p.x = req_tdata[15:0]; p.y = req_tdata[31:16]; p.z = req_tdata[47:32];
         p.last = req_tlast;
         fit_point(p);
         points_sent++;
      end
   end

   // monitor
   always @(posedge clock) begin
      cycles++;
      if (!reset) rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      if (!reset && rsp_tvalid && rsp_tready) begin
         box_type a, e;
         a.cx = rsp_tdata[15:0]; a.cy = rsp_tdata[31:16]; a.cz = rsp_tdata[47:32];
         a.len = rsp_tdata[64:48]; a.wid = rsp_tdata[81:65]; a.hgt = rsp_tdata[97:82];
         a.yaw = rsp_tdata[105:98];
         a.all_used = rsp_tuser[0]; a.dropped = rsp_tuser[1];
         boxes_seen++;
         if (boxes_due.size() == 0) begin
            $display("%0t: unexpected box %p", $realtime, a);
            errors++;
         end else begin
            e = boxes_due.pop_front();
            if (a !== e) begin
               $display("%0t: box mismatch expected %p actual %p", $realtime, e, a);
               errors++;
            end
         end
      end
   end

   function automatic logic signed [15:0] rnd_coord(int span);
      if ($urandom_range(19) == 0) return 16'($urandom);
      return 16'($signed($urandom_range(2 * span)) - span);
   endfunction

   task automatic add_cluster(int n, int span);
      point_type p;
      int cx, cy, cz, i;
      cx = $signed($urandom_range(8000)) - 4000;
      cy = $signed($urandom_range(8000)) - 4000;
      cz = $signed($urandom_range(2000)) - 1000;
      for (i = 0; i < n; i++) begin
         p.x = 16'(cx + rnd_coord(span)); p.y = 16'(cy + rnd_coord(span));
         p.z = 16'(cz + rnd_coord(span / 2 + 1));
         p.last = (i == n - 1);
         pending_pts.insert(pending_pts.size(), p);
      end
   endtask

   task automatic add_point(int x, int y, int z, bit last);
      point_type p;
      p.x = 16'(x); p.y = 16'(y); p.z = 16'(z); p.last = last;
      pending_pts.insert(pending_pts.size(), p);
   endtask

   task automatic drain();
      longint t0;
      t0 = cycles;
      while ((pending_pts.size() > 0 || req_tvalid || boxes_due.size() > 0)
             && cycles - t0 < 2000000) @(posedge clock);
      repeat (2500) @(posedge clock);
   endtask

   task automatic write_reg(logic [0:0] idx, int val);
      @(posedge clock);
      csr_we <= 1'b1; csr_index <= idx; csr_wdata <= 15'(val);
      if (idx == CSR_CUT) cut_ofs = val & 16'h7FFF;
      else min_above = val & 11'h7FF;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   initial begin
      int ph, n;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, single point, flat cluster, overflow
      add_point(32767, 32767, 32767, 1);
      add_point(-32768, -32768, -32768, 0);
      add_point(32767, -32768, 0, 0);
      add_point(-32768, 32767, 100, 1);
      add_point(0, 0, 0, 0);
      add_point(0, 0, 0, 1);
      add_point(0, 0, 0, 0);
      add_point(2560, 0, 500, 0);
      add_point(0, 512, 600, 0);
      add_point(2560, 512, 700, 1);
      add_point(0, 0, 10, 0);
      add_point(1000, 0, 10, 0);
      add_point(0, 3000, 10, 1);
      add_point(100, 200, -50, 0);
      add_point(-300, 250, 60, 0);
      add_point(5, -400, 200, 1);
      drain();
      for (n = 0; n < STORE_DEPTH + 3; n++)
         add_point(n * 7 - 3000, (n * 13) % 4000, n % 300, n == STORE_DEPTH + 2);
      drain();

      for (ph = 0; ph < 8; ph++) begin
         case (ph % 4)
            0: begin send_idle_pct = 0; recv_stall_pct = 0; end
            1: begin send_idle_pct = 54; recv_stall_pct = 0; end
            2: begin send_idle_pct = 0; recv_stall_pct = 54; end
            default: begin send_idle_pct = 23; recv_stall_pct = 23; end
         endcase
         case (ph)
            0: write_reg(CSR_CUT, 0);
            1: write_reg(CSR_MINP, 1);
            2: write_reg(CSR_CUT, 32767);
            3: write_reg(CSR_MINP, 1024);
            4: write_reg(CSR_CUT, $urandom_range(600));
            default: write_reg(CSR_MINP, $urandom_range(1, 12));
         endcase
         for (n = 0; n < 20; n++)
            add_cluster($urandom_range(1, 10), $urandom_range(3) == 0 ? 30000 : 600);
         drain();
      end
      $display("Ran %0d points and checked %0d boxes across 8 register and idle settings,",
               points_sent, boxes_seen);
      $display("including coordinate extremes, store overflow and low-point cut fallback.");
      if (errors == 0 && boxes_due.size() == 0)
         $display("min_area_box_fit_top verification clean");
      else
         $display("min_area_box_fit_top verification failed");
      $finish;
   end

   always @(posedge clock) begin
      if (cycles > 3000000) begin
         $display("min_area_box_fit_top verification failed");
         $finish;
      end
   end
endmodule
`default_nettype wire
